FILE: rtl/cftr_pkg.sv
// ----------------------------------------------------------------------------
// cftr_pkg
// Shared types and constants of the camera frame timestamp recovery block.
// ----------------------------------------------------------------------------
package cftr_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 33;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_WRAP  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_CYCLE  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PER   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAMES  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SHIFT = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_MAX   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_MIN   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SHUT_STEP   = 4'd7;

	// Embedded word decoding.
	localparam logic [26:0] SEC_US        = 27'd1000000;
	localparam logic [26:0] CYCLE_US      = 27'd125;
	localparam logic [22:0] OFFSET_RECIP  = 23'd1311;
	localparam logic [31:0] SHUTTER_VALID = 32'h7000_0000;
	localparam logic [19:0] SHUTTER_MASK  = 20'hF_FFFF;
	localparam logic [38:0] HALF_US_NS    = 39'd500;
	localparam logic signed [31:0] US_NS  = 32'sd1000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WRAP,
		ST_START,
		ST_GAP,
		ST_BRANCH,
		ST_DIV,
		ST_UPD,
		ST_M1GO,
		ST_M1,
		ST_M2GO,
		ST_M2,
		ST_FIN1,
		ST_FIN2,
		ST_OUT
	} cftr_state_t;

	typedef struct packed {
		logic load_in;
		logic decode;
		logic wrap;
		logic start;
		logic gap;
		logic branch;
		logic div_start;
		logic div_sel;   // 1: receive time / sync cycle, 0: gap magnitude / period
		logic upd;
		logic mul_start;
		logic mul_sel;   // 0: epoch * sync cycle, 1: frames * period
		logic cap1;
		logic fin1;
		logic fin2;
		logic out_load;
	} cftr_cmd_t;

	typedef struct packed {
		logic match;
		logic sync_zero;
		logic period_zero;
		logic div_done;
		logic mul_done;
		logic out_free;
	} cftr_sts_t;

endpackage

FILE: rtl/cftr_ifs.sv
// ----------------------------------------------------------------------------
// cftr interfaces
// Valid/ready channels for frame items, results and configuration writes.
// ----------------------------------------------------------------------------
interface cftr_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] raw_timestamp;
	logic [31:0] raw_shutter;
	logic [62:0] receive_time_ns;
	modport source(output valid, raw_timestamp, raw_shutter, receive_time_ns, input ready);
	modport sink(input valid, raw_timestamp, raw_shutter, receive_time_ns, output ready);
endinterface

interface cftr_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] frame_time_ns;
	logic               synced;
	logic               sync_maybe_lost;
	modport source(output valid, frame_time_ns, synced, sync_maybe_lost, input ready);
	modport sink(input valid, frame_time_ns, synced, sync_maybe_lost, output ready);
endinterface

interface cftr_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [32:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/cftr_div.sv
// ----------------------------------------------------------------------------
// cftr_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module cftr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic [63:0] quotient,
	output logic [31:0] remainder,
	output logic        done
);

	logic [63:0] n_q;
	logic [31:0] r_q;
	logic [31:0] d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rs;
	logic        qbit;

	assign rs   = {r_q, n_q[63]};
	assign qbit = rs >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[62:0], qbit};
			r_q <= qbit ? 32'(rs - {1'b0, d_q}) : rs[31:0];
		end
	end

	assign quotient  = n_q;
	assign remainder = r_q;
	assign done      = done_q;

endmodule

FILE: rtl/cftr_mul.sv
// ----------------------------------------------------------------------------
// cftr_mul
// Shift-and-add multiplier, 64-bit by 32-bit, keeping the low 64 bits.
// ----------------------------------------------------------------------------
module cftr_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [31:0] b,
	output logic [63:0] product,
	output logic        done
);

	logic [63:0] a_q;
	logic [31:0] b_q;
	logic [63:0] acc_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[62:0], 1'b0};
			b_q <= {1'b0, b_q[31:1]};
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule

FILE: rtl/cftr_dp.sv
// ----------------------------------------------------------------------------
// cftr_dp
// Datapath: configuration registers, frame state, decode, shared divider and
// multiplier, result assembly and output register.
// ----------------------------------------------------------------------------
module cftr_dp import cftr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cftr_cmd_t             cmd,
	output cftr_sts_t             sts,
	input  logic [31:0]           raw_timestamp,
	input  logic [31:0]           raw_shutter,
	input  logic [62:0]           receive_time_ns,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [63:0]    frame_time_ns,
	output logic                  synced,
	output logic                  sync_maybe_lost
);

	// Configuration
	logic [31:0]        clock_wrap_q;
	logic [31:0]        sync_cycle_q;
	logic [23:0]        period_q;
	logic [15:0]        max_frames_q;
	logic signed [20:0] shift_q;
	logic signed [32:0] match_max_q;
	logic signed [32:0] match_min_q;
	logic [9:0]         step_q;

	// Frame state
	logic [26:0] prev_cam_q;
	logic [63:0] wrap_q;
	logic [63:0] prev_start_q;
	logic [63:0] epoch_q;
	logic [63:0] frames_q;
	logic        seen_q;

	// Per-item working registers
	logic [31:0] ts_q;
	logic [31:0] sh_q;
	logic [62:0] rx_q;
	logic [26:0] cam_q;
	logic [29:0] shut_q;
	logic [63:0] start_q;
	logic [63:0] gap_q;
	logic        match_q;
	logic        neg_q;
	logic [63:0] prod1_q;
	logic [63:0] p2k_q;
	logic [63:0] shk_q;
	logic [63:0] shiftk_q;
	logic [63:0] sum_q;
	logic        out_valid_q;
	logic signed [63:0] out_time_q;
	logic        out_synced_q;
	logic        out_lost_q;

	logic [22:0] off_prod;
	logic [26:0] cam_nxt;
	logic [19:0] steps;
	logic [29:0] shut_nxt;
	logic        match;
	logic [63:0] mag;
	logic [63:0] div_q;
	logic [31:0] div_r;
	logic        div_done;
	logic [63:0] div_n;
	logic [31:0] div_d;
	logic        round_up;
	logic [63:0] q_rnd;
	logic [63:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic        mul_done;
	logic signed [31:0] shift_ns;
	logic        lost;

	// Offset in 1/25 us: multiply by 1311/32768, exact for all 12-bit inputs.
	assign off_prod = 23'(ts_q[11:0]) * OFFSET_RECIP;
	assign cam_nxt  = 27'(ts_q[31:25]) * SEC_US + 27'(ts_q[24:12]) * CYCLE_US
	                + 27'(off_prod[22:15]);
	assign steps    = (sh_q > SHUTTER_VALID) ? (sh_q[19:0] & SHUTTER_MASK) : '0;
	assign shut_nxt = 30'(steps) * 30'(step_q);

	assign match = ($signed(gap_q) < 64'(match_max_q)) && ($signed(gap_q) > 64'(match_min_q));
	assign mag   = gap_q[63] ? 64'(-gap_q) : gap_q;

	assign div_n = cmd.div_sel ? {1'b0, rx_q} : mag;
	assign div_d = cmd.div_sel ? sync_cycle_q : {8'd0, period_q};

	cftr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_n),
		.divisor   (div_d),
		.quotient  (div_q),
		.remainder (div_r),
		.done      (div_done)
	);

	// Ties round away from zero: bump when twice the remainder reaches the period.
	assign round_up = {div_r, 1'b0} >= {9'd0, period_q};
	assign q_rnd    = div_q + 64'(round_up);

	assign mul_a = cmd.mul_sel ? frames_q : epoch_q;
	assign mul_b = cmd.mul_sel ? {8'd0, period_q} : sync_cycle_q;

	cftr_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.product (mul_p),
		.done    (mul_done)
	);

	assign shift_ns = 32'(shift_q) * US_NS;
	assign lost     = seen_q && !frames_q[63] && (frames_q > 64'(max_frames_q));

	assign sts.match       = match;
	assign sts.sync_zero   = sync_cycle_q == '0;
	assign sts.period_zero = period_q == '0;
	assign sts.div_done    = div_done;
	assign sts.mul_done    = mul_done;
	assign sts.out_free    = !out_valid_q || out_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_wrap_q <= 32'd128000000;
			sync_cycle_q <= 32'd1000000000;
			period_q     <= 24'd100000;
			max_frames_q <= 16'd10;
			shift_q      <= '0;
			match_max_q  <= 33'sd400000;
			match_min_q  <= 33'sd150000;
			step_q       <= 10'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CLOCK_WRAP:  clock_wrap_q <= cfg_data[31:0];
				REG_SYNC_CYCLE:  sync_cycle_q <= cfg_data[31:0];
				REG_FRAME_PER:   period_q     <= cfg_data[23:0];
				REG_MAX_FRAMES:  max_frames_q <= cfg_data[15:0];
				REG_FIRST_SHIFT: shift_q      <= cfg_data[20:0];
				REG_MATCH_MAX:   match_max_q  <= cfg_data;
				REG_MATCH_MIN:   match_min_q  <= cfg_data;
				REG_SHUT_STEP:   step_q       <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_cam_q   <= '0;
			wrap_q       <= '0;
			prev_start_q <= '0;
			epoch_q      <= '0;
			frames_q     <= '0;
			seen_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.wrap) begin
				if (prev_cam_q > cam_q) begin
					wrap_q <= wrap_q + 64'(clock_wrap_q);
				end
				prev_cam_q <= cam_q;
			end
			if (cmd.gap) begin
				prev_start_q <= start_q;
			end
			if (cmd.upd) begin
				if (match_q) begin
					epoch_q  <= (sync_cycle_q == '0) ? '0 : div_q;
					frames_q <= 64'd1;
					seen_q   <= 1'b1;
				end else if (period_q != '0) begin
					frames_q <= neg_q ? frames_q - q_rnd : frames_q + q_rnd;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			ts_q <= raw_timestamp;
			sh_q <= raw_shutter;
			rx_q <= receive_time_ns;
		end
		if (cmd.decode) begin
			cam_q  <= cam_nxt;
			shut_q <= shut_nxt;
		end
		if (cmd.start) begin
			start_q <= wrap_q + 64'(cam_q) - 64'(shut_q);
		end
		if (cmd.gap) begin
			gap_q <= start_q - prev_start_q;
		end
		if (cmd.branch) begin
			match_q <= match;
			neg_q   <= gap_q[63];
		end
		if (cmd.cap1) begin
			prod1_q <= mul_p;
		end
		if (cmd.fin1) begin
			// x * 1000 = x * 1024 - x * 32 + x * 8
			p2k_q    <= {mul_p[53:0], 10'd0} - {mul_p[58:0], 5'd0} + {mul_p[60:0], 3'd0};
			shk_q    <= 64'(39'(shut_q) * HALF_US_NS);
			shiftk_q <= (frames_q == 64'd1) ? 64'(shift_ns) : '0;
		end
		if (cmd.fin2) begin
			sum_q <= prod1_q + p2k_q;
		end
		if (cmd.out_load) begin
			out_time_q   <= sum_q + shiftk_q + shk_q;
			out_synced_q <= seen_q;
			out_lost_q   <= lost;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_time_ns   = out_time_q;
	assign synced          = out_synced_q;
	assign sync_maybe_lost = out_lost_q;

endmodule

FILE: rtl/cftr_ctrl.sv
// ----------------------------------------------------------------------------
// cftr_ctrl
// Controller: sequences one frame item through decode, unwrap, gap match,
// division when one is needed, the two products and result assembly.
// ----------------------------------------------------------------------------
module cftr_ctrl import cftr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output cftr_cmd_t cmd,
	input  cftr_sts_t sts
);

	cftr_state_t state_q;
	cftr_state_t state_nxt;
	logic        need_div;

	// A sync gap divides the receive time, any other gap divides its magnitude.
	assign need_div = sts.match ? !sts.sync_zero : !sts.period_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = ST_DECODE;
			ST_DECODE: state_nxt = ST_WRAP;
			ST_WRAP:   state_nxt = ST_START;
			ST_START:  state_nxt = ST_GAP;
			ST_GAP:    state_nxt = ST_BRANCH;
			ST_BRANCH: state_nxt = need_div ? ST_DIV : ST_UPD;
			ST_DIV:    if (sts.div_done) state_nxt = ST_UPD;
			ST_UPD:    state_nxt = ST_M1GO;
			ST_M1GO:   state_nxt = ST_M1;
			ST_M1:     if (sts.mul_done) state_nxt = ST_M2GO;
			ST_M2GO:   state_nxt = ST_M2;
			ST_M2:     if (sts.mul_done) state_nxt = ST_FIN1;
			ST_FIN1:   state_nxt = ST_FIN2;
			ST_FIN2:   state_nxt = ST_OUT;
			ST_OUT:    if (sts.out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_DECODE: cmd.decode = 1'b1;
			ST_WRAP:   cmd.wrap   = 1'b1;
			ST_START:  cmd.start  = 1'b1;
			ST_GAP:    cmd.gap    = 1'b1;
			ST_BRANCH: begin
				cmd.branch    = 1'b1;
				cmd.div_start = need_div;
				cmd.div_sel   = sts.match;
			end
			ST_DIV:    ;
			ST_UPD:    cmd.upd = 1'b1;
			ST_M1GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = 1'b0;
			end
			ST_M1:     cmd.cap1 = sts.mul_done;
			ST_M2GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = 1'b1;
			end
			ST_M2:     ;
			ST_FIN1:   cmd.fin1 = 1'b1;
			ST_FIN2:   cmd.fin2 = 1'b1;
			ST_OUT:    cmd.out_load = sts.out_free;
			default:   ;
		endcase
	end

endmodule

FILE: rtl/camera_frame_timestamp_recovery.sv
// Flow: each input item passes through decode, unwrap, start, gap and branch
// states, a division when needed, two multiplies and result assembly, and
// waits until the output register is free. Items are handled one at a time; the
// next item is taken while the result still waits in the output register.
// Reset: arst_n clears all frame state and loads register defaults; no sweep.
// ----------------------------------------------------------------------------
// camera_frame_timestamp_recovery
// Recovers a mid-exposure frame time in ns from embedded camera timestamps,
// with clock unwrapping, sync gap detection and frame counting.
// ----------------------------------------------------------------------------
module camera_frame_timestamp_recovery import cftr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cftr_in_if.sink     in_ch,
	cftr_out_if.source  out_ch,
	cftr_cfg_if.sink    cfg
);

	cftr_cmd_t cmd;
	cftr_sts_t sts;

	cftr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	cftr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.raw_timestamp   (in_ch.raw_timestamp),
		.raw_shutter     (in_ch.raw_shutter),
		.receive_time_ns (in_ch.receive_time_ns),
		.cfg_valid       (cfg.valid),
		.cfg_ready       (cfg.ready),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.out_valid       (out_ch.valid),
		.out_ready       (out_ch.ready),
		.frame_time_ns   (out_ch.frame_time_ns),
		.synced          (out_ch.synced),
		.sync_maybe_lost (out_ch.sync_maybe_lost)
	);

endmodule
